>>> rtl/sdtq_pkg.sv
// Package for the sorted deadline timer queue: word types, codes, FSM states
// and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package sdtq_pkg;

  localparam int CAPACITY_DEF  = 16;
  localparam int ID_BITS_DEF   = 8;
  localparam int TIME_BITS_DEF = 32;

  // fixed field widths of the words
  localparam int ID_W    = 8;
  localparam int TIME_W  = 32;
  localparam int COUNT_W = 5;

  // most timers popped by one tick
  localparam int MAX_RESULTS = 16;
  localparam int TICK_W      = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_ADJUST = 2'd2,
    REQ_TICK   = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_DUP_ID    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_REMOVE,
    S_INSERT,
    S_RESP,
    S_TICK
  } state_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [ID_W-1:0]   timer_id;
    logic [TIME_W-1:0] deadline;
    logic [TIME_W-1:0] now_time;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               fired;
    logic [ID_W-1:0]    expired_id;
    logic [COUNT_W-1:0] entry_count;
    logic               last;
  } rsp_t;

  typedef struct packed {
    logic    load;
    logic    lookup;
    logic    remove;
    logic    insert;
    logic    pop;
    logic    emit;
    status_t emit_status;
    logic    emit_fired;
    logic    emit_last;
  } cmd_t;

  typedef struct packed {
    req_kind_t kind;
    logic      found;
    logic      full;
    logic      head_expired;
    logic      next_expired;
    logic      out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/sdtq_datapath.sv
// Datapath of the timer queue: request register, sorted slot registers with
// parallel compare-and-shift, and the output word register.
// Depends on sdtq_pkg.
`default_nettype none

module sdtq_datapath import sdtq_pkg::*; #(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int ID_BITS   = ID_BITS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire req_t req,
  output rsp_t      rsp,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  input  wire cmd_t cmd,
  output sts_t      sts
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = $clog2(CAPACITY);

  req_kind_t            kind;
  logic [ID_BITS-1:0]   rid;
  logic [TIME_BITS-1:0] rdl;
  logic [TIME_BITS-1:0] rnow;

  logic [ID_BITS-1:0]   slot_id      [CAPACITY];
  logic [TIME_BITS-1:0] slot_dl      [CAPACITY];
  logic [ID_BITS-1:0]   slot_id_next [CAPACITY];
  logic [TIME_BITS-1:0] slot_dl_next [CAPACITY];

  logic [CW-1:0]       count, count_next;
  logic [PW-1:0]       pos, pos_hit, shift_pos;
  logic [CAPACITY-1:0] hit, le;

  logic [ID_W+15:0]        id_wide;
  logic [2*TIME_W-1:0]     dl_wide, now_wide;
  logic [ID_W+ID_BITS-1:0] head_wide;
  logic [COUNT_W+CW-1:0]   count_wide;
  rsp_t                    rsp_next;

  assign id_wide    = {16'b0, req.timer_id};
  assign dl_wide    = {32'b0, req.deadline};
  assign now_wide   = {32'b0, req.now_time};
  assign head_wide  = {{ID_W{1'b0}}, slot_id[0]};
  assign count_wide = {{COUNT_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind <= req_kind_t'(req.req_type);
      rid  <= id_wide[ID_BITS-1:0];
      rdl  <= dl_wide[TIME_BITS-1:0];
      rnow <= now_wide[TIME_BITS-1:0];
    end
    if (cmd.lookup) pos <= pos_hit;
  end

  // per-slot id match and deadline <= new deadline; the latter is a prefix
  always_comb begin
    pos_hit = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit[i] = (CW'(i) < count) && (slot_id[i] == rid);
      le[i]  = (CW'(i) < count) && (slot_dl[i] <= rdl);
      if (hit[i]) pos_hit = pos_hit | PW'(i);
    end
  end

  always_comb begin
    shift_pos  = cmd.pop ? '0 : pos;
    count_next = count;
    for (int i = 0; i < CAPACITY; i++) begin
      slot_id_next[i] = slot_id[i];
      slot_dl_next[i] = slot_dl[i];
    end
    if (cmd.remove || cmd.pop) begin
      count_next = count - CW'(1);
      for (int i = 0; i < CAPACITY - 1; i++) begin
        if (PW'(i) >= shift_pos) begin
          slot_id_next[i] = slot_id[i+1];
          slot_dl_next[i] = slot_dl[i+1];
        end
      end
    end else if (cmd.insert) begin
      count_next = count + CW'(1);
      if (!le[0]) begin
        slot_id_next[0] = rid;
        slot_dl_next[0] = rdl;
      end
      for (int i = 1; i < CAPACITY; i++) begin
        if (!le[i]) begin
          if (le[i-1]) begin
            slot_id_next[i] = rid;
            slot_dl_next[i] = rdl;
          end else begin
            slot_id_next[i] = slot_id[i-1];
            slot_dl_next[i] = slot_dl[i-1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
    for (int i = 0; i < CAPACITY; i++) begin
      slot_id[i] <= slot_id_next[i];
      slot_dl[i] <= slot_dl_next[i];
    end
  end

  always_comb begin
    rsp_next.status      = cmd.emit_status;
    rsp_next.fired       = cmd.emit_fired;
    rsp_next.expired_id  = cmd.emit_fired ? head_wide[ID_W-1:0] : '0;
    rsp_next.entry_count = count_wide[COUNT_W-1:0];
    rsp_next.last        = cmd.emit_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
    if (cmd.emit) rsp <= rsp_next;
  end

  assign sts.kind         = kind;
  assign sts.found        = |hit;
  assign sts.full         = (count == CW'(CAPACITY));
  assign sts.head_expired = (count != '0) && (slot_dl[0] <= rnow);
  assign sts.next_expired = (count > CW'(1)) && (slot_dl[1] <= rnow);
  assign sts.out_free     = !rsp_valid || !rsp_stall;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("timer count above capacity");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!rsp_valid || !rsp_stall))
    else $error("word emitted over a pending word");

  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |-> (count != CW'(CAPACITY)) && !(cmd.remove || cmd.pop))
    else $error("insert into full queue or with a removal");

  a_remove_held: assert property (@(posedge clk) disable iff (rst)
    (cmd.remove || cmd.pop) |-> (count != '0))
    else $error("removal from empty queue");

endmodule

`default_nettype wire

>>> rtl/sdtq_ctrl.sv
// Controller FSM of the timer queue: sequences lookup, remove, insert, tick
// pops and result emission through commands to the datapath.
// Depends on sdtq_pkg.
`default_nettype none

module sdtq_ctrl import sdtq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  output cmd_t      cmd,
  input  wire sts_t sts
);

  state_t             state, state_next;
  status_t            status_q, status_q_next;
  logic [TICK_W-1:0]  tick_n, tick_n_next;
  logic               tick_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      status_q <= ST_OK;
      tick_n   <= '0;
    end else begin
      state    <= state_next;
      status_q <= status_q_next;
      tick_n   <= tick_n_next;
    end
  end

  // the pop is the last one unless the next head has expired too and MAX_RESULTS pops are not yet reached
  assign tick_last = !(sts.next_expired && (tick_n < TICK_W'(MAX_RESULTS - 1)));

  always_comb begin
    state_next      = state;
    status_q_next   = status_q;
    tick_n_next     = tick_n;
    cmd             = '0;
    cmd.emit_status = ST_OK;
    req_stall       = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load    = 1'b1;
          tick_n_next = '0;
          state_next  = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd.lookup    = 1'b1;
        status_q_next = ST_OK;
        if (sts.kind == REQ_TICK) begin
          state_next = S_TICK;
        end else if (sts.kind == REQ_ADD) begin
          if (sts.found) begin
            status_q_next = ST_DUP_ID;
            state_next    = S_RESP;
          end else if (sts.full) begin
            status_q_next = ST_FULL;
            state_next    = S_RESP;
          end else begin
            state_next = S_INSERT;
          end
        end else if (!sts.found) begin
          status_q_next = ST_NOT_FOUND;
          state_next    = S_RESP;
        end else begin
          state_next = S_REMOVE;
        end
      end
      S_REMOVE: begin
        cmd.remove = 1'b1;
        state_next = (sts.kind == REQ_ADJUST) ? S_INSERT : S_RESP;
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = status_q;
          cmd.emit_last   = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_TICK: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.head_expired && (tick_n < TICK_W'(MAX_RESULTS))) begin
            cmd.pop        = 1'b1;
            cmd.emit_fired = 1'b1;
            cmd.emit_last  = tick_last;
            tick_n_next    = tick_n + TICK_W'(1);
            if (tick_last) state_next = S_IDLE;
          end else begin
            cmd.emit_last = 1'b1;
            state_next    = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/sorted_deadline_timer_queue_unit.sv
// Sorted deadline timer queue. Add: lookup, insert; delete: lookup, remove;
// adjust: lookup, remove, insert; rejected: lookup; all then a response word;
// tick: one word per expired timer popped. A stalled output word delays the
// next one. One request at a time; the next is taken in the cycle after its
// last word is issued. Synchronous reset empties the queue; slot contents are
// not cleared. Depends on sdtq_pkg, sdtq_ctrl and sdtq_datapath.
`default_nettype none

module sorted_deadline_timer_queue_unit import sdtq_pkg::*; #(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int ID_BITS   = ID_BITS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  cmd_t cmd;
  sts_t sts;

  sdtq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  sdtq_datapath #(
    .CAPACITY  (CAPACITY),
    .ID_BITS   (ID_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire
